// File: src/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
// no dependencies

package uer_pkg;

  localparam int PeriodW   = 16;
  localparam int MaxEchoW  = 20;
  localparam int SpeedW    = 10;
  localparam int StampW    = 32;
  localparam int DistW     = 29;
  localparam int ProdW     = MaxEchoW + SpeedW;
  localparam int AddrW     = 4;
  localparam int DataW     = 32;

  localparam logic [1:0] REG_PERIOD    = 2'd0;
  localparam logic [1:0] REG_MAX_ECHO  = 2'd1;
  localparam logic [1:0] REG_SPEED     = 2'd2;

  localparam logic [PeriodW-1:0]  PERIOD_RESET   = 16'd60;
  localparam logic [MaxEchoW-1:0] MAX_ECHO_RESET = 20'd25000;
  localparam logic [SpeedW-1:0]   SPEED_RESET    = 10'd340;

  localparam logic [PeriodW-1:0] MS_SAT = {PeriodW{1'b1}};

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'b001,
    PH_TRIG_END  = 3'b010,
    PH_ECHO_WAIT = 3'b100
  } phase_t;

endpackage

// File: src/ultrasonic_echo_ranger.sv
// ultrasonic echo ranger top level: input register, sequencer update, result register
// depends on uer_pkg

// Usage:
//   in channel: opcode (tick or echo edge) and capture_value, with in_valid/in_stall.
//   out channel: one result word per input word: trig_level, measurement_done,
//   distance_valid, distance_um, with out_valid/out_stall.
//   an input word is registered, then the sequencer state and the result register
//   are updated from it when it advances out of the input register.
//   throughput is one word per cycle while the receiver does not stall; the distance
//   product is a single 20 x 10 bit multiply in the result path.
//   when the receiver stalls, the result register holds; one more word can wait in
//   the input register, after which in_stall rises until the result is taken.
//   synchronous reset clears the pipeline, the sequencer (idle, no edges, trigger low,
//   distance zero and invalid) and loads the register defaults 60 ms, 25000 us,
//   340 m/s. registers sit on the APB port at byte addresses 0, 4 and 8 and should
//   be written only while no word is in flight.

module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              opcode,
  input  logic [StampW-1:0] capture_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              trig_level,
  output logic              measurement_done,
  output logic              distance_valid,
  output logic [DistW-1:0]  distance_um,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  logic [PeriodW-1:0]  period_ms;
  logic [MaxEchoW-1:0] max_echo_us;
  logic [SpeedW-1:0]   sound_speed;

  logic              s1_valid;
  logic              s1_opcode;
  logic [StampW-1:0] s1_capture;
  logic              s1_adv;
  logic              in_accept;

  phase_t            phase, phase_next;
  logic [1:0]        edge_count, edge_count_next;
  logic [StampW-1:0] echo_start, echo_start_next;
  logic [StampW-1:0] echo_end, echo_end_next;
  logic [PeriodW-1:0] ms_since_trigger, ms_since_trigger_next;
  logic              trigger_pin, trigger_pin_next;
  logic [DistW-1:0]  last_distance, last_distance_next;
  logic              last_valid, last_valid_next;
  logic              done;

  logic [PeriodW-1:0] ms_inc;
  logic [StampW-1:0]  dur;
  logic               dur_ok;
  logic [ProdW-1:0]   product;
  logic               cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms   <= PERIOD_RESET;
      max_echo_us <= MAX_ECHO_RESET;
      sound_speed <= SPEED_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PERIOD:   period_ms   <= pwdata[PeriodW-1:0];
        REG_MAX_ECHO: max_echo_us <= pwdata[MaxEchoW-1:0];
        REG_SPEED:    sound_speed <= pwdata[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PERIOD:   prdata = {{(DataW-PeriodW){1'b0}}, period_ms};
      REG_MAX_ECHO: prdata = {{(DataW-MaxEchoW){1'b0}}, max_echo_us};
      REG_SPEED:    prdata = {{(DataW-SpeedW){1'b0}}, sound_speed};
      default:      prdata = '0;
    endcase
  end

  // handshake and input register
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode  <= opcode;
      s1_capture <= capture_value;
    end
  end

  // sequencer update
  assign ms_inc  = (ms_since_trigger != MS_SAT) ? ms_since_trigger + 1'b1 : ms_since_trigger;
  assign dur     = echo_end - echo_start;
  assign dur_ok  = (dur != '0) && (dur < {{(StampW-MaxEchoW){1'b0}}, max_echo_us});
  assign product = dur[MaxEchoW-1:0] * sound_speed;

  always_comb begin
    phase_next            = phase;
    edge_count_next       = edge_count;
    echo_start_next       = echo_start;
    echo_end_next         = echo_end;
    ms_since_trigger_next = ms_since_trigger;
    trigger_pin_next      = trigger_pin;
    last_distance_next    = last_distance;
    last_valid_next       = last_valid;
    done                  = 1'b0;
    if (s1_opcode == OP_EDGE) begin
      if (edge_count == 2'd0) begin
        echo_start_next = s1_capture;
        edge_count_next = 2'd1;
      end else if (edge_count == 2'd1) begin
        echo_end_next   = s1_capture;
        edge_count_next = 2'd2;
      end
    end else begin
      ms_since_trigger_next = ms_inc;
      case (phase)
        PH_IDLE: begin
          if (ms_inc >= period_ms) begin
            trigger_pin_next      = 1'b1;
            ms_since_trigger_next = '0;
            edge_count_next       = 2'd0;
            phase_next            = PH_TRIG_END;
          end
        end
        PH_TRIG_END: begin
          if (ms_inc >= PeriodW'(1)) begin
            trigger_pin_next = 1'b0;
            phase_next       = PH_ECHO_WAIT;
          end
        end
        PH_ECHO_WAIT: begin
          if (edge_count == 2'd2) begin
            if (dur_ok) begin
              last_distance_next = product[ProdW-1:1];
              last_valid_next    = 1'b1;
            end else begin
              last_valid_next = 1'b0;
            end
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else if (ms_inc >= period_ms) begin
            last_valid_next = 1'b0;
            edge_count_next = 2'd0;
            phase_next      = PH_IDLE;
            done            = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      edge_count       <= 2'd0;
      echo_start       <= '0;
      echo_end         <= '0;
      ms_since_trigger <= '0;
      trigger_pin      <= 1'b0;
      last_distance    <= '0;
      last_valid       <= 1'b0;
    end else if (s1_adv) begin
      phase            <= phase_next;
      edge_count       <= edge_count_next;
      echo_start       <= echo_start_next;
      echo_end         <= echo_end_next;
      ms_since_trigger <= ms_since_trigger_next;
      trigger_pin      <= trigger_pin_next;
      last_distance    <= last_distance_next;
      last_valid       <= last_valid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      trig_level       <= trigger_pin_next;
      measurement_done <= done;
      distance_valid   <= last_valid_next;
      distance_um      <= last_distance_next;
    end
  end

endmodule

// File: src/uer_checker.sv
// port-level checks for the ultrasonic echo ranger, bound to the top level
// depends on uer_pkg and ultrasonic_echo_ranger

module uer_checker
  import uer_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              trig_level,
  input logic              measurement_done,
  input logic              distance_valid,
  input logic [DistW-1:0]  distance_um
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance_um) && $stable(trig_level)
      && $stable(measurement_done) && $stable(distance_valid))
    else $error("stalled result word changed");

  // with the result register empty the input side never stalls
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // a measurement ends only while the trigger is low
  a_done_trig_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && measurement_done |-> !trig_level)
    else $error("measurement done with trigger high");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .trig_level       (trig_level),
  .measurement_done (measurement_done),
  .distance_valid   (distance_valid),
  .distance_um      (distance_um)
);
